>>> sv/sgbs_pkg.sv
`default_nettype none

package sgbs_pkg;

    localparam int MAX_ENTRIES_DEF = 1024;
    localparam int GRID_X_BITS_DEF = 5;
    localparam int GRID_Y_BITS_DEF = 5;

    localparam int UNIT_W  = 16;
    localparam int COORD_W = 16;
    localparam int INDEX_W = 11;
    localparam int VALUE_W = 16;

    localparam logic [1:0] OP_LOAD       = 2'd0;
    localparam logic [1:0] OP_READ_SLOT  = 2'd1;
    localparam logic [1:0] OP_READ_START = 2'd2;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_RANGE     = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;
    localparam logic [1:0] ST_NOT_BUILT = 2'd3;

    typedef struct packed {
        logic [1:0]                op;
        logic [UNIT_W-1:0]         unit_number;
        logic signed [COORD_W-1:0] cell_x;
        logic signed [COORD_W-1:0] cell_y;
        logic                      final_entry;
        logic [INDEX_W-1:0]        read_index;
    } t_cmd;

    typedef struct packed {
        logic [VALUE_W-1:0] read_value;
        logic [1:0]         status;
    } t_result;

endpackage

`default_nettype wire

>>> sv/sgbs_ram.sv
`default_nettype none

module sgbs_ram
    import sgbs_pkg::*;
#(
    parameter int WIDTH = UNIT_W,
    parameter int DEPTH = MAX_ENTRIES_DEF
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

>>> sv/sgbs_cursor.sv
`default_nettype none

// Per-bucket counter store. Read data appears in the cycle after the address and
// already includes a write to the same entry made in the read cycle.
module sgbs_cursor
    import sgbs_pkg::*;
#(
    parameter int WIDTH = $clog2(MAX_ENTRIES_DEF + 1),
    parameter int DEPTH = 1 << (GRID_X_BITS_DEF + GRID_Y_BITS_DEF)
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata
);

    localparam int AW = $clog2(DEPTH);

    logic [WIDTH-1:0] ram_q;
    logic [AW-1:0]    r_raddr;
    logic             r_fwd_v;
    logic [AW-1:0]    r_fwd_addr;
    logic [WIDTH-1:0] r_fwd_data;

    sgbs_ram #(
        .WIDTH (WIDTH),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_we),
        .i_waddr (i_waddr),
        .i_wdata (i_wdata),
        .i_raddr (i_raddr),
        .o_rdata (ram_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_v <= 1'b0;
        end else begin
            r_fwd_v <= i_we;
        end
        r_raddr    <= i_raddr;
        r_fwd_addr <= i_waddr;
        r_fwd_data <= i_wdata;
    end

    // The memory returns the old word when read and write hit one entry.
    assign o_rdata = (r_fwd_v && (r_fwd_addr == r_raddr)) ? r_fwd_data : ram_q;

endmodule

`default_nettype wire

>>> sv/spatial_grid_bucket_sort_core.sv
`default_nettype none

// Channel   Ports                            Transaction
// command   start, busy, i_cmd (t_cmd)       start && !busy at a rising edge
// result    o_result_valid, o_result         result valid for one cycle, no backpressure
//
// Load and read commands are taken while busy is low; a read answers on the next cycle.
// A load with final_entry set starts the build: a prefix pass over all buckets,
// a scatter over the loaded entries and a pass that zeroes the bucket counters;
// busy is high. After reset the same zeroing pass runs before busy falls.
// Results cannot be stalled; each appears on o_result for one cycle.
module spatial_grid_bucket_sort_core
    import sgbs_pkg::*;
#(
    parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
    parameter int GRID_X_BITS = GRID_X_BITS_DEF,
    parameter int GRID_Y_BITS = GRID_Y_BITS_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic start,
    input  wire t_cmd i_cmd,
    output logic      busy,
    output logic      o_result_valid,
    output t_result   o_result
);

    localparam int BB      = GRID_X_BITS + GRID_Y_BITS;
    localparam int BUCKETS = 1 << BB;
    localparam int AW      = $clog2(MAX_ENTRIES);
    localparam int CW      = $clog2(MAX_ENTRIES + 1);
    localparam int EW      = UNIT_W + BB;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_PREFIX,
        S_SCATTER
    } t_state;

    typedef enum logic [1:0] {
        SRC_ZERO,
        SRC_SORT,
        SRC_START,
        SRC_TOTAL
    } t_src;

    t_state            r_state;
    logic [BB:0]       r_ptr;
    logic [CW-1:0]     r_eidx;
    logic [CW-1:0]     r_total;
    logic              r_built;
    logic [CW-1:0]     r_run;
    logic              r_ld_v;
    logic [BB-1:0]     r_ld_bk;
    logic              r_pf_v;
    logic [BB-1:0]     r_pf_addr;
    logic              r_sa_v;
    logic              r_sb_v;
    logic [BB-1:0]     r_sb_bk;
    logic [UNIT_W-1:0] r_sb_unit;
    logic              r_res_v;
    logic [1:0]        r_res_status;
    t_src              r_res_src;

    logic              accept;
    logic [BB-1:0]     bk;
    logic [CW-1:0]     total_eff;
    logic              can_load;
    logic              do_store;
    logic [CW-1:0]     n_total;
    logic [31:0]       idx32;
    logic              res_fire;
    logic [1:0]        res_status;
    t_src              res_src;

    logic [EW-1:0]     ent_q;
    logic [BB-1:0]     ent_bk;
    logic [UNIT_W-1:0] ent_unit;
    logic [BB-1:0]     cur_raddr;
    logic [CW-1:0]     cur_q;
    logic              cur_we;
    logic [BB-1:0]     cur_waddr;
    logic [CW-1:0]     cur_wdata;
    logic [CW-1:0]     start_q;
    logic [UNIT_W-1:0] sort_q;
    logic [31:0]       start_q32;
    logic [31:0]       total32;

    assign busy     = (r_state != S_IDLE);
    assign accept   = start && !busy;
    assign bk       = {i_cmd.cell_y[GRID_Y_BITS-1:0], i_cmd.cell_x[GRID_X_BITS-1:0]};
    assign total_eff = r_built ? '0 : r_total;
    assign can_load = (total_eff < CW'(MAX_ENTRIES));
    assign do_store = accept && (i_cmd.op == OP_LOAD) && can_load;
    assign n_total  = do_store ? (total_eff + CW'(1)) : total_eff;
    assign idx32    = 32'(i_cmd.read_index);
    assign ent_bk   = ent_q[BB-1:0];
    assign ent_unit = ent_q[EW-1:BB];

    always_comb begin
        res_fire   = 1'b0;
        res_status = ST_OK;
        res_src    = SRC_ZERO;
        unique case (i_cmd.op)
            OP_LOAD: begin
                res_fire   = !can_load;
                res_status = ST_FULL;
            end
            OP_READ_SLOT: begin
                res_fire = 1'b1;
                if (!r_built) begin
                    res_status = ST_NOT_BUILT;
                end else if (idx32 < 32'(r_total)) begin
                    res_src = SRC_SORT;
                end else begin
                    res_status = ST_RANGE;
                end
            end
            OP_READ_START: begin
                res_fire = 1'b1;
                if (!r_built) begin
                    res_status = ST_NOT_BUILT;
                end else if (idx32 < 32'(BUCKETS)) begin
                    res_src = SRC_START;
                end else if (idx32 == 32'(BUCKETS)) begin
                    res_src = SRC_TOTAL;
                end else begin
                    res_status = ST_RANGE;
                end
            end
            default: ;
        endcase
    end

    always_comb begin
        unique case (r_state)
            S_IDLE:    cur_raddr = bk;
            S_SCATTER: cur_raddr = ent_bk;
            default:   cur_raddr = r_ptr[BB-1:0];
        endcase
    end

    always_comb begin
        cur_we    = 1'b1;
        cur_waddr = r_ptr[BB-1:0];
        cur_wdata = '0;
        priority if (r_ld_v) begin
            cur_waddr = r_ld_bk;
            cur_wdata = cur_q + CW'(1);
        end else if (r_pf_v) begin
            cur_waddr = r_pf_addr;
            cur_wdata = r_run;
        end else if (r_sb_v) begin
            cur_waddr = r_sb_bk;
            cur_wdata = cur_q + CW'(1);
        end else begin
            cur_we = (r_state == S_CLEAR);
        end
    end

    sgbs_ram #(
        .WIDTH (EW),
        .DEPTH (MAX_ENTRIES)
    ) u_entries (
        .i_clk   (i_clk),
        .i_we    (do_store),
        .i_waddr (total_eff[AW-1:0]),
        .i_wdata ({i_cmd.unit_number, bk}),
        .i_raddr (r_eidx[AW-1:0]),
        .o_rdata (ent_q)
    );

    sgbs_cursor #(
        .WIDTH (CW),
        .DEPTH (BUCKETS)
    ) u_cursor (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_raddr (cur_raddr),
        .o_rdata (cur_q),
        .i_we    (cur_we),
        .i_waddr (cur_waddr),
        .i_wdata (cur_wdata)
    );

    sgbs_ram #(
        .WIDTH (CW),
        .DEPTH (BUCKETS)
    ) u_starts (
        .i_clk   (i_clk),
        .i_we    (r_pf_v),
        .i_waddr (r_pf_addr),
        .i_wdata (r_run),
        .i_raddr (idx32[BB-1:0]),
        .o_rdata (start_q)
    );

    sgbs_ram #(
        .WIDTH (UNIT_W),
        .DEPTH (MAX_ENTRIES)
    ) u_sorted (
        .i_clk   (i_clk),
        .i_we    (r_sb_v),
        .i_waddr (cur_q[AW-1:0]),
        .i_wdata (r_sb_unit),
        .i_raddr (idx32[AW-1:0]),
        .o_rdata (sort_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_ptr   <= '0;
            r_eidx  <= '0;
            r_total <= '0;
            r_built <= 1'b0;
            r_ld_v  <= 1'b0;
            r_pf_v  <= 1'b0;
            r_sa_v  <= 1'b0;
            r_sb_v  <= 1'b0;
            r_res_v <= 1'b0;
        end else begin
            r_ld_v  <= do_store;
            r_pf_v  <= (r_state == S_PREFIX) && !r_ptr[BB];
            r_sa_v  <= (r_state == S_SCATTER) && (r_eidx < r_total);
            r_sb_v  <= r_sa_v;
            r_res_v <= accept && res_fire;
            unique case (r_state)
                S_CLEAR: begin
                    r_ptr <= r_ptr + (BB+1)'(1);
                    if (r_ptr == (BB+1)'(BUCKETS - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (accept && (i_cmd.op == OP_LOAD)) begin
                        r_built <= 1'b0;
                        r_total <= n_total;
                        if (i_cmd.final_entry) begin
                            r_state <= S_PREFIX;
                            r_ptr   <= '0;
                            r_run   <= '0;
                        end
                    end
                end
                S_PREFIX: begin
                    if (r_pf_v) begin
                        r_run <= r_run + cur_q;
                    end
                    if (r_ptr[BB]) begin
                        r_state <= S_SCATTER;
                        r_eidx  <= '0;
                    end else begin
                        r_ptr <= r_ptr + (BB+1)'(1);
                    end
                end
                S_SCATTER: begin
                    if (r_eidx < r_total) begin
                        r_eidx <= r_eidx + CW'(1);
                    end else if (!r_sa_v && !r_sb_v) begin
                        // counters go back to zero for the next set
                        r_state <= S_CLEAR;
                        r_ptr   <= '0;
                        r_built <= 1'b1;
                    end
                end
            endcase
        end
        r_ld_bk      <= bk;
        r_pf_addr    <= r_ptr[BB-1:0];
        r_sb_bk      <= ent_bk;
        r_sb_unit    <= ent_unit;
        r_res_status <= res_status;
        r_res_src    <= res_src;
    end

    assign start_q32 = 32'(start_q);
    assign total32   = 32'(r_total);

    always_comb begin
        o_result.status = r_res_status;
        unique case (r_res_src)
            SRC_ZERO:  o_result.read_value = '0;
            SRC_SORT:  o_result.read_value = sort_q;
            SRC_START: o_result.read_value =
                (start_q32 > 32'hFFFF) ? 16'hFFFF : start_q32[VALUE_W-1:0];
            SRC_TOTAL: o_result.read_value =
                (total32 > 32'hFFFF) ? 16'hFFFF : total32[VALUE_W-1:0];
        endcase
    end

    assign o_result_valid = r_res_v;

    a_result_follows_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> $past(accept))
        else $error("result without a command");

    a_slot_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCATTER && r_sb_v) |-> (cur_q < r_total))
        else $error("scatter slot beyond entry total");

    a_total_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        do_store |=> (r_total == $past(total_eff) + CW'(1)))
        else $error("entry total did not advance on load");

    a_idle_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !(r_pf_v || r_sa_v || r_sb_v))
        else $error("build pipeline active while idle");

endmodule

`default_nettype wire
